>>> hw/rtl/cds_pkg.sv
// shared types, constants and calendar helper functions for the date stepper
`default_nettype none
package cds_pkg;

	localparam int MAX_STEP_DEF  = 1024;
	localparam int YEAR_BITS_DEF = 14;
	localparam int DELTA_W       = 11;
	localparam int DEF_YEAR_BASE = 2023;
	localparam int YEAR_CYCLE    = 400;
	localparam int MOD_W         = 9;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_APR = 4'd4;
	localparam logic [3:0] MONTH_JUN = 4'd6;
	localparam logic [3:0] MONTH_SEP = 4'd9;
	localparam logic [3:0] MONTH_NOV = 4'd11;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	localparam logic [4:0] DAYS_28 = 5'd28;
	localparam logic [4:0] DAYS_29 = 5'd29;
	localparam logic [4:0] DAYS_30 = 5'd30;
	localparam logic [4:0] DAYS_31 = 5'd31;

	localparam logic [MOD_W-1:0] CENT_1 = 9'd100;
	localparam logic [MOD_W-1:0] CENT_2 = 9'd200;
	localparam logic [MOD_W-1:0] CENT_3 = 9'd300;
	localparam logic [MOD_W-1:0] MOD_TOP = 9'd399;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_MOD,
		ST_LOAD_CHK,
		ST_STEP,
		ST_FINISH
	} cds_state_t;

	typedef struct packed {
		logic capture;
		logic shift;
		logic commit_load;
		logic move;
		logic set_limit;
		logic publish;
	} cds_cmd_t;

	typedef struct packed {
		logic mod_last;
		logic steps_zero;
		logic blocked;
	} cds_status_t;

	// leap from year mod 400
	function automatic logic is_leap(input logic [MOD_W-1:0] mod400);
		is_leap = (mod400[1:0] == 2'b00) && (mod400 != CENT_1) &&
			(mod400 != CENT_2) && (mod400 != CENT_3);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		case (m)
			MONTH_FEB: month_len = leap ? DAYS_29 : DAYS_28;
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: month_len = DAYS_30;
			default: month_len = DAYS_31;
		endcase
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cds_ctrl.sv
// controller state machine for the date stepper
`default_nettype none
module cds_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic                 cmd,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output cds_pkg::cds_cmd_t         ctl,
	input  wire cds_pkg::cds_status_t sts
);
	import cds_pkg::*;

	cds_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d     = (cmd == CMD_LOAD) ? ST_LOAD_MOD : ST_STEP;
				end
			end
			ST_LOAD_MOD: begin
				ctl.shift = 1'b1;
				if (sts.mod_last) begin
					state_d = ST_LOAD_CHK;
				end
			end
			ST_LOAD_CHK: begin
				ctl.commit_load = 1'b1;
				state_d         = ST_FINISH;
			end
			ST_STEP: begin
				if (sts.steps_zero) begin
					state_d = ST_FINISH;
				end else if (sts.blocked) begin
					ctl.set_limit = 1'b1;
					state_d       = ST_FINISH;
				end else begin
					ctl.move = 1'b1;
				end
			end
			ST_FINISH: begin
				// result register free or being emptied this cycle
				if (!out_valid_q || !out_stall) begin
					ctl.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

>>> hw/rtl/cds_dp.sv
// datapath of the date stepper: date registers, mod-400 unit, day counter, result register
`default_nettype none
module cds_dp #(
	parameter int MAX_STEP  = cds_pkg::MAX_STEP_DEF,
	parameter int YEAR_BITS = cds_pkg::YEAR_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cds_pkg::cds_cmd_t             ctl,
	output cds_pkg::cds_status_t               sts,
	input  wire logic [4:0]                    load_day,
	input  wire logic [3:0]                    load_month,
	input  wire logic [YEAR_BITS-1:0]          load_year,
	input  wire logic signed [cds_pkg::DELTA_W-1:0] day_delta,
	output logic [4:0]                         day,
	output logic [3:0]                         month,
	output logic [YEAR_BITS-1:0]               year,
	output logic                               load_rejected,
	output logic                               limit_hit
);
	import cds_pkg::*;

	localparam int CNT_W      = $clog2(MAX_STEP + 1);
	localparam int CMP_W      = (CNT_W > DELTA_W) ? CNT_W : DELTA_W;
	localparam int YEAR_MAX_I = (1 << YEAR_BITS) - 1;
	localparam int DEF_YEAR_I = (DEF_YEAR_BASE > YEAR_MAX_I) ? YEAR_MAX_I : DEF_YEAR_BASE;
	localparam int RECIP_SH   = 29;
	localparam int PROD_W     = RECIP_SH + YEAR_BITS;
	localparam logic [YEAR_BITS-1:0] YEAR_MAX = YEAR_BITS'(YEAR_MAX_I);
	localparam logic [YEAR_BITS-1:0] DEF_YEAR = YEAR_BITS'(DEF_YEAR_I);
	localparam logic [YEAR_BITS-1:0] YEAR_ONE = YEAR_BITS'(1);
	localparam logic [MOD_W-1:0]     DEF_MOD  = MOD_W'(DEF_YEAR_I % YEAR_CYCLE);
	// rounded-up reciprocal of 400, exact quotient for years below 2^20
	localparam logic [PROD_W-1:0]    RECIP_M  = PROD_W'((1 << RECIP_SH) / YEAR_CYCLE + 1);
	localparam logic [YEAR_BITS-1:0] CYC_Y    = YEAR_BITS'(YEAR_CYCLE);

	// captured load beat
	logic [4:0]           ld_day_q;
	logic [3:0]           ld_month_q;
	logic [YEAR_BITS-1:0] ld_year_q;
	logic [YEAR_BITS-1:0] quo_q;
	logic [MOD_W-1:0]     rem_q;
	logic                 mod_ph_q;
	logic                 back_q;
	logic [CNT_W-1:0]     steps_q;

	// current date
	logic [4:0]           cur_day_q;
	logic [3:0]           cur_month_q;
	logic [YEAR_BITS-1:0] cur_year_q;
	logic [MOD_W-1:0]     cur_mod_q;
	logic                 rej_q;
	logic                 lim_q;

	// result register
	logic [4:0]           day_q;
	logic [3:0]           month_q;
	logic [YEAR_BITS-1:0] year_q;
	logic                 load_rejected_q;
	logic                 limit_hit_q;

	logic [DELTA_W-1:0]   raw;
	logic [DELTA_W-1:0]   mag;
	logic [CMP_W-1:0]     sat;
	logic [PROD_W-1:0]    prod;
	logic [YEAR_BITS-1:0] yr_sub;
	logic                 ld_ok;
	logic [4:0]           len_cur;
	logic [4:0]           len_prev;
	logic                 cur_leap;
	logic [4:0]           mv_day;
	logic [3:0]           mv_month;
	logic [YEAR_BITS-1:0] mv_year;
	logic [MOD_W-1:0]     mv_mod;

	always_comb begin
		raw = day_delta;
		mag = raw[DELTA_W-1] ? (~raw + DELTA_W'(1)) : raw;
		sat = (CMP_W'(mag) > CMP_W'(MAX_STEP)) ? CMP_W'(MAX_STEP) : CMP_W'(mag);

		// year mod 400: quotient by reciprocal multiply, then remainder by subtract
		prod   = PROD_W'(ld_year_q) * RECIP_M;
		yr_sub = ld_year_q - quo_q * CYC_Y;

		ld_ok = (ld_day_q != 5'd0) && (ld_month_q >= MONTH_JAN) &&
			(ld_month_q <= MONTH_DEC) && (ld_year_q != '0) &&
			(ld_day_q <= month_len(ld_month_q, is_leap(rem_q)));

		cur_leap = is_leap(cur_mod_q);
		len_cur  = month_len(cur_month_q, cur_leap);
		len_prev = month_len(cur_month_q - 4'd1, cur_leap);

		mv_day   = cur_day_q;
		mv_month = cur_month_q;
		mv_year  = cur_year_q;
		mv_mod   = cur_mod_q;
		if (!back_q) begin
			if (cur_day_q < len_cur) begin
				mv_day = cur_day_q + 5'd1;
			end else if (cur_month_q < MONTH_DEC) begin
				mv_day   = 5'd1;
				mv_month = cur_month_q + 4'd1;
			end else begin
				mv_day   = 5'd1;
				mv_month = MONTH_JAN;
				mv_year  = cur_year_q + YEAR_ONE;
				mv_mod   = (cur_mod_q == MOD_TOP) ? '0 : cur_mod_q + MOD_W'(1);
			end
		end else begin
			if (cur_day_q > 5'd1) begin
				mv_day = cur_day_q - 5'd1;
			end else if (cur_month_q > MONTH_JAN) begin
				mv_day   = len_prev;
				mv_month = cur_month_q - 4'd1;
			end else begin
				mv_day   = DAYS_31;
				mv_month = MONTH_DEC;
				mv_year  = cur_year_q - YEAR_ONE;
				mv_mod   = (cur_mod_q == '0) ? MOD_TOP : cur_mod_q - MOD_W'(1);
			end
		end

		sts.mod_last   = mod_ph_q;
		sts.steps_zero = (steps_q == '0);
		sts.blocked    = back_q ?
			((cur_day_q == 5'd1) && (cur_month_q == MONTH_JAN) && (cur_year_q == YEAR_ONE)) :
			((cur_day_q == DAYS_31) && (cur_month_q == MONTH_DEC) && (cur_year_q == YEAR_MAX));
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			ld_day_q   <= load_day;
			ld_month_q <= load_month;
			ld_year_q  <= load_year;
			back_q     <= raw[DELTA_W-1];
		end else if (ctl.shift) begin
			if (!mod_ph_q) begin
				quo_q <= prod[RECIP_SH +: YEAR_BITS];
			end else begin
				rem_q <= MOD_W'(yr_sub);
			end
		end
		if (ctl.publish) begin
			day_q           <= cur_day_q;
			month_q         <= cur_month_q;
			year_q          <= cur_year_q;
			load_rejected_q <= rej_q;
			limit_hit_q     <= lim_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_day_q   <= 5'd1;
			cur_month_q <= MONTH_JAN;
			cur_year_q  <= DEF_YEAR;
			cur_mod_q   <= DEF_MOD;
			steps_q     <= '0;
			mod_ph_q    <= 1'b0;
			rej_q       <= 1'b0;
			lim_q       <= 1'b0;
		end else begin
			if (ctl.capture) begin
				mod_ph_q <= 1'b0;
				steps_q  <= sat[CNT_W-1:0];
				rej_q    <= 1'b0;
				lim_q    <= 1'b0;
			end else if (ctl.shift) begin
				mod_ph_q <= !mod_ph_q;
			end
			if (ctl.commit_load) begin
				if (ld_ok) begin
					cur_day_q   <= ld_day_q;
					cur_month_q <= ld_month_q;
					cur_year_q  <= ld_year_q;
					cur_mod_q   <= rem_q;
				end else begin
					cur_day_q   <= 5'd1;
					cur_month_q <= MONTH_JAN;
					cur_year_q  <= DEF_YEAR;
					cur_mod_q   <= DEF_MOD;
					rej_q       <= 1'b1;
				end
			end
			if (ctl.move) begin
				cur_day_q   <= mv_day;
				cur_month_q <= mv_month;
				cur_year_q  <= mv_year;
				cur_mod_q   <= mv_mod;
				steps_q     <= steps_q - CNT_W'(1);
			end
			if (ctl.set_limit) begin
				lim_q   <= 1'b1;
				steps_q <= '0;
			end
		end
	end

	assign day           = day_q;
	assign month         = month_q;
	assign year          = year_q;
	assign load_rejected = load_rejected_q;
	assign limit_hit     = limit_hit_q;

endmodule
`default_nettype wire

>>> hw/rtl/calendar_date_stepper.sv
// top level of the calendar date stepper
// Holds a day/month/year date. An input beat with cmd = load checks the
// date against the Gregorian month lengths and stores it, or stores
// 1/1/2023 and flags load_rejected. A beat with cmd = step moves the date
// by the signed day_delta, clipped to MAX_STEP days, one day per cycle,
// and flags limit_hit if the year range end stops it.
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. Exactly one result beat follows each input beat.
// For a load, the year mod 400 is found by a reciprocal multiply and then
// a subtract, and the date is then checked and stored; for a step, the
// day counter moves the date one day per cycle for min(|day_delta|,
// MAX_STEP) days. One item is in work at a time; the next input beat is
// taken the cycle after the result is loaded into the output register.
// A finished result waits in the output register while the receiver
// stalls; a further result waits in the controller until it is free.
// Reset clears the date to 1/1/2023 and empties the output register.
`default_nettype none
module calendar_date_stepper #(
	parameter int MAX_STEP  = cds_pkg::MAX_STEP_DEF,
	parameter int YEAR_BITS = cds_pkg::YEAR_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              cmd,
	input  wire logic [4:0]                        load_day,
	input  wire logic [3:0]                        load_month,
	input  wire logic [YEAR_BITS-1:0]              load_year,
	input  wire logic signed [cds_pkg::DELTA_W-1:0] day_delta,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [4:0]                             day,
	output logic [3:0]                             month,
	output logic [YEAR_BITS-1:0]                   year,
	output logic                                   load_rejected,
	output logic                                   limit_hit
);
	import cds_pkg::*;

	cds_cmd_t    ctl;
	cds_status_t sts;

	cds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl),
		.sts       (sts)
	);

	cds_dp #(
		.MAX_STEP  (MAX_STEP),
		.YEAR_BITS (YEAR_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.sts           (sts),
		.load_day      (load_day),
		.load_month    (load_month),
		.load_year     (load_year),
		.day_delta     (day_delta),
		.day           (day),
		.month         (month),
		.year          (year),
		.load_rejected (load_rejected),
		.limit_hit     (limit_hit)
	);

endmodule
`default_nettype wire
